[design/sha1_stream_hasher_unit_macros.svh]
// assertion macros for the sha1 stream hasher
// no dependencies; included by sha1_stream_hasher_unit, which carries assertions
`ifndef SHA1_STREAM_HASHER_UNIT_MACROS_SVH
`define SHA1_STREAM_HASHER_UNIT_MACROS_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define SHA1_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sha1 assertion failed");
// antecedent implies consequent in the next cycle
`define SHA1_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sha1 assertion failed");
`else
`define SHA1_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SHA1_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[design/sha1sh_pkg.sv]
// shared types, constants and round functions of the sha1 stream hasher
// no dependencies
package sha1sh_pkg;

	localparam int WORD_W   = 32;
	localparam int BLK_WRDS = 16;
	localparam int CHAIN_N  = 5;
	localparam int RND_W    = 7;

	localparam logic [RND_W-1:0] LAST_ROUND = 7'd79;
	localparam logic [2:0]       LAST_IDX   = 3'd4;
	localparam logic [7:0]       PAD_BYTE   = 8'h80;

	localparam logic [WORD_W-1:0] H_INIT [CHAIN_N] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_INIT  = 5'b00010,
		S_ROUND = 5'b00100,
		S_FIN   = 5'b01000,
		S_OUT   = 5'b10000
	} state_t;

	// what feeds rounds 0..15 of a compression
	typedef enum logic [1:0] {
		BK_DATA = 2'd0,
		BK_PAD1 = 2'd1,
		BK_PAD2 = 2'd2
	} blk_kind_t;

	function automatic logic [WORD_W-1:0] k_round(input logic [RND_W-1:0] rnd);
		logic [WORD_W-1:0] k;
		if (rnd < 7'd20)
			k = 32'h5A827999;
		else if (rnd < 7'd40)
			k = 32'h6ED9EBA1;
		else if (rnd < 7'd60)
			k = 32'h8F1BBCDC;
		else
			k = 32'hCA62C1D6;
		return k;
	endfunction

	function automatic logic [WORD_W-1:0] f_round(input logic [RND_W-1:0] rnd,
			input logic [WORD_W-1:0] b, input logic [WORD_W-1:0] c,
			input logic [WORD_W-1:0] d);
		logic [WORD_W-1:0] f;
		if (rnd < 7'd20)
			f = (b & c) | (~b & d);
		else if (rnd < 7'd40 || rnd >= 7'd60)
			f = b ^ c ^ d;
		else
			f = (b & c) | (b & d) | (c & d);
		return f;
	endfunction

endpackage

[design/sha1_stream_hasher_unit.sv]
// sha1 stream hasher: byte stream in, five digest words out
// depends on sha1sh_pkg and sha1_stream_hasher_unit_macros.svh
// input: a byte that does not close a block is taken without a stall; the 64th byte of a
//   block holds the input off through the load, 80 rounds and chain update
// end of message: one or two pad blocks (plus a data block if the same byte closes
//   one), then five output words, one per cycle when taken
// no byte is taken while a block is being compressed or while the digest is output
// reset: arst_n clears control, reloads the initial chain and zeroes the byte count
`include "sha1_stream_hasher_unit_macros.svh"

module sha1_stream_hasher_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] byte_valid
	input  logic        s_axis_tlast,   // end_of_message
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
	output logic        m_axis_tlast    // last_word
);
	import sha1sh_pkg::*;

	// control state
	state_t            state_q;
	blk_kind_t         kind_q;
	logic [RND_W-1:0]  rnd_q;
	logic [2:0]        idx_q;
	logic [63:0]       cnt_q;
	logic              eom_pend_q;
	logic [WORD_W-1:0] chain_q [CHAIN_N];

	// datapath registers, no reset needed
	logic [WORD_W-1:0] acc_q;
	logic [WORD_W-1:0] pad_word_q;
	logic [3:0]        pad_idx_q;
	logic              two_blk_q;
	logic [63:0]       len_q;
	logic [WORD_W-1:0] wv_q [CHAIN_N];
	logic [WORD_W-1:0] sched_q [BLK_WRDS];

	// block store: one write port (byte packing), one registered read port (rounds)
	logic [WORD_W-1:0] blk_mem [BLK_WRDS];
	logic [WORD_W-1:0] rdata_q;
	logic              mem_we;
	logic [3:0]        mem_waddr;
	logic [3:0]        mem_raddr;

	logic              in_fire;
	logic              out_fire;
	logic              byte_vld;
	logic [5:0]        pos;
	logic [5:0]        pos_e;
	logic [WORD_W-1:0] acc_new;
	logic [WORD_W-1:0] pad_new;
	logic [63:0]       cnt_new;
	logic              blk_full;

	logic [3:0]        r4;
	logic [WORD_W-1:0] w_ld;
	logic [WORD_W-1:0] w_xor;
	logic [WORD_W-1:0] w_cur;
	logic [WORD_W-1:0] t_sum;

	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;
	assign byte_vld = s_axis_tuser;

	// byte packing: big-endian within the word, first byte in bits 31:24
	assign pos     = cnt_q[5:0];
	assign cnt_new = cnt_q + {63'd0, byte_vld};
	assign pos_e   = cnt_new[5:0];

	always_comb begin
		acc_new = acc_q;
		if (byte_vld) begin
			if (pos[1:0] == 2'd0)
				acc_new = {s_axis_tdata, 24'd0};
			else
				acc_new = acc_q | ({24'd0, s_axis_tdata} << {~pos[1:0], 3'b000});
		end
	end

	// word that carries the 0x80 marker, merged with any bytes already in it
	always_comb begin
		if (pos_e[1:0] == 2'd0)
			pad_new = {PAD_BYTE, 24'd0};
		else
			pad_new = acc_new | ({24'd0, PAD_BYTE} << {~pos_e[1:0], 3'b000});
	end

	assign blk_full  = byte_vld && (pos == 6'd63);
	assign mem_we    = in_fire && byte_vld && (pos[1:0] == 2'd3);
	assign mem_waddr = pos[5:2];
	// read one word ahead so that rdata_q holds word r during round r
	assign mem_raddr = (state_q == S_INIT) ? 4'd0 : (rnd_q[3:0] + 4'd1);

	always_ff @(posedge clk) begin
		if (mem_we)
			blk_mem[mem_waddr] <= acc_new;
		rdata_q <= blk_mem[mem_raddr];
	end

	// message word for rounds 0..15, by block kind
	assign r4 = rnd_q[3:0];

	always_comb begin
		case (kind_q)
			BK_DATA: w_ld = rdata_q;
			BK_PAD1: begin
				if (r4 < pad_idx_q)
					w_ld = rdata_q;
				else if (r4 == pad_idx_q)
					w_ld = pad_word_q;
				else if (!two_blk_q && r4 == 4'd14)
					w_ld = len_q[63:32];
				else if (!two_blk_q && r4 == 4'd15)
					w_ld = len_q[31:0];
				else
					w_ld = '0;
			end
			BK_PAD2: begin
				if (r4 == 4'd14)
					w_ld = len_q[63:32];
				else if (r4 == 4'd15)
					w_ld = len_q[31:0];
				else
					w_ld = '0;
			end
			default: w_ld = '0;
		endcase
	end

	// schedule expansion from the 16-word window: taps r-3, r-8, r-14, r-16
	assign w_xor = sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0];
	assign w_cur = (rnd_q < 7'd16) ? w_ld : {w_xor[30:0], w_xor[31]};

	assign t_sum = {wv_q[0][26:0], wv_q[0][31:27]}
		+ f_round(rnd_q, wv_q[1], wv_q[2], wv_q[3])
		+ wv_q[4] + k_round(rnd_q) + w_cur;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			kind_q     <= BK_DATA;
			rnd_q      <= '0;
			idx_q      <= '0;
			cnt_q      <= '0;
			eom_pend_q <= 1'b0;
			for (int i = 0; i < CHAIN_N; i++)
				chain_q[i] <= H_INIT[i];
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						cnt_q <= cnt_new;
						if (blk_full) begin
							// full data block first, padding follows if the message ends
							kind_q     <= BK_DATA;
							eom_pend_q <= s_axis_tlast;
							state_q    <= S_INIT;
						end else if (s_axis_tlast) begin
							kind_q  <= BK_PAD1;
							state_q <= S_INIT;
						end
					end
				end
				S_INIT: begin
					rnd_q   <= '0;
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == LAST_ROUND)
						state_q <= S_FIN;
				end
				S_FIN: begin
					for (int i = 0; i < CHAIN_N; i++)
						chain_q[i] <= chain_q[i] + wv_q[i];
					case (kind_q)
						BK_DATA: begin
							if (eom_pend_q) begin
								kind_q     <= BK_PAD1;
								eom_pend_q <= 1'b0;
								state_q    <= S_INIT;
							end else begin
								state_q <= S_IDLE;
							end
						end
						BK_PAD1: begin
							if (two_blk_q) begin
								// marker left no room for the length
								kind_q  <= BK_PAD2;
								state_q <= S_INIT;
							end else begin
								idx_q   <= '0;
								state_q <= S_OUT;
							end
						end
						default: begin
							idx_q   <= '0;
							state_q <= S_OUT;
						end
					endcase
				end
				S_OUT: begin
					if (out_fire) begin
						if (idx_q == LAST_IDX) begin
							// ready for the next message
							for (int i = 0; i < CHAIN_N; i++)
								chain_q[i] <= H_INIT[i];
							cnt_q   <= '0;
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_fire) begin
			acc_q <= acc_new;
			if (s_axis_tlast) begin
				pad_word_q <= pad_new;
				pad_idx_q  <= pos_e[5:2];
				two_blk_q  <= (pos_e[5:3] == 3'b111);
				len_q      <= {cnt_new[60:0], 3'b000};
			end
		end
		if (state_q == S_INIT) begin
			for (int i = 0; i < CHAIN_N; i++)
				wv_q[i] <= chain_q[i];
		end
		if (state_q == S_ROUND) begin
			wv_q[0] <= t_sum;
			wv_q[1] <= wv_q[0];
			wv_q[2] <= {wv_q[1][1:0], wv_q[1][31:2]};
			wv_q[3] <= wv_q[2];
			wv_q[4] <= wv_q[3];
			for (int i = 0; i < BLK_WRDS - 1; i++)
				sched_q[i] <= sched_q[i+1];
			sched_q[BLK_WRDS-1] <= w_cur;
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = (state_q == S_OUT);
	assign m_axis_tdata  = {5'd0, idx_q, chain_q[idx_q]};
	assign m_axis_tlast  = (idx_q == LAST_IDX);

	`SHA1_ASSERT_SAME(a_no_in_while_out, clk, arst_n, m_axis_tvalid, !s_axis_tready)
	`SHA1_ASSERT_SAME(a_mem_wr_idle, clk, arst_n, mem_we, state_q == S_IDLE)
	`SHA1_ASSERT_SAME(a_rnd_range, clk, arst_n, state_q == S_ROUND, rnd_q <= LAST_ROUND)
	`SHA1_ASSERT_SAME(a_idx_range, clk, arst_n, m_axis_tvalid, idx_q <= LAST_IDX)
	`SHA1_ASSERT_NEXT(a_msg_restart, clk, arst_n, out_fire && m_axis_tlast,
		state_q == S_IDLE && cnt_q == 64'd0)

endmodule
